// ===== rtl/aks_pkg.sv =====
// types, constants and s-box table for the aes-128 key schedule
`default_nettype none
package aks_pkg;

  localparam int unsigned ROUND_W = 4;
  localparam logic [ROUND_W-1:0] LAST_ROUND = 4'd10;
  localparam logic [7:0] RCON_INIT = 8'h01;
  localparam logic [7:0] RCON_POLY = 8'h1b;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic last;
  } status_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

endpackage
`default_nettype wire

// ===== rtl/aks_datapath.sv =====
// round key register, round counter, round constant and next-key logic
`default_nettype none
module aks_datapath (
  input  wire logic                        clk,
  input  wire aks_pkg::cmd_t               cmd,
  output aks_pkg::status_t                 status,
  input  wire logic [63:0]                 in_key_high,
  input  wire logic [63:0]                 in_key_low,
  output logic [aks_pkg::ROUND_W-1:0]      round_number,
  output logic [63:0]                      round_key_high,
  output logic [63:0]                      round_key_low
);

  logic [127:0]                 key_r, key_nxt;
  logic [aks_pkg::ROUND_W-1:0]  round_r, round_nxt;
  logic [7:0]                   rcon_r, rcon_nxt;

  logic [31:0] w0, w1, w2, w3;
  logic [31:0] rot, sub, t;
  logic [31:0] n0, n1, n2, n3;

  always_comb begin
    w0 = key_r[127:96];
    w1 = key_r[95:64];
    w2 = key_r[63:32];
    w3 = key_r[31:0];
    rot = {w3[23:0], w3[31:24]};
    sub = {aks_pkg::SBOX[rot[31:24]], aks_pkg::SBOX[rot[23:16]],
           aks_pkg::SBOX[rot[15:8]],  aks_pkg::SBOX[rot[7:0]]};
    t  = sub ^ {rcon_r, 24'h000000};
    n0 = w0 ^ t;
    n1 = w1 ^ n0;
    n2 = w2 ^ n1;
    n3 = w3 ^ n2;

    key_nxt   = key_r;
    round_nxt = round_r;
    rcon_nxt  = rcon_r;
    if (cmd.load) begin
      key_nxt   = {in_key_high, in_key_low};
      round_nxt = '0;
      rcon_nxt  = aks_pkg::RCON_INIT;
    end else if (cmd.step) begin
      key_nxt   = {n0, n1, n2, n3};
      round_nxt = round_r + aks_pkg::ROUND_W'(1);
      rcon_nxt  = {rcon_r[6:0], 1'b0} ^ (rcon_r[7] ? aks_pkg::RCON_POLY : 8'h00);
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    round_r <= round_nxt;
    rcon_r  <= rcon_nxt;
  end

  assign status.last     = (round_r == aks_pkg::LAST_ROUND);
  assign round_number    = round_r;
  assign round_key_high  = key_r[127:64];
  assign round_key_low   = key_r[63:0];

endmodule
`default_nettype wire

// ===== rtl/aks_ctrl.sv =====
// controller state machine for the key schedule
`default_nettype none
module aks_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  input  wire aks_pkg::status_t  status,
  output aks_pkg::cmd_t          cmd
);

  aks_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= aks_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    out_valid = 1'b0;
    in_stall  = 1'b1;
    cmd       = '0;
    case (state_r)
      aks_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
        if (in_valid) begin
          state_nxt = aks_pkg::ST_RUN;
        end
      end
      aks_pkg::ST_RUN: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          if (status.last) begin
            in_stall  = 1'b0;
            cmd.load  = in_valid;
            state_nxt = in_valid ? aks_pkg::ST_RUN : aks_pkg::ST_IDLE;
          end else begin
            cmd.step = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = aks_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/aes128_key_schedule_top.sv =====
// top level of the aes-128 key schedule
// input channel: one beat carries a 128-bit cipher key as in_key_high and
// in_key_low; accepted when in_valid is high and in_stall low
// result channel: eleven beats per key, round keys 0 to 10 in order, each
// with out_round_number, out_round_key_high, out_round_key_low and
// out_last_round set on round 10
// latency: round key 0 is shown the cycle after the key beat is taken
// throughput: one round key per cycle when the receiver does not stall, from
// a single round unit (one rotate, four s-box lookups and the word xor
// chain); the next key is taken in the cycle the last round key is taken
// a stall on the result channel holds the shown round key and freezes the
// schedule; no new key is taken until all eleven beats have gone
// reset returns the controller to idle and drops any schedule in progress;
// nothing is kept between keys
`default_nettype none
module aes128_key_schedule_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [63:0] in_key_high,
  input  wire logic [63:0] in_key_low,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       out_round_number,
  output logic [63:0]      out_round_key_high,
  output logic [63:0]      out_round_key_low,
  output logic             out_last_round
);

  aks_pkg::cmd_t    cmd;
  aks_pkg::status_t status;

  aks_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  aks_datapath u_datapath (
    .clk            (clk),
    .cmd            (cmd),
    .status         (status),
    .in_key_high    (in_key_high),
    .in_key_low     (in_key_low),
    .round_number   (out_round_number),
    .round_key_high (out_round_key_high),
    .round_key_low  (out_round_key_low)
  );

  assign out_last_round = status.last;

  // key beat starts a schedule at round 0
  a_start_round0 : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (out_valid && out_round_number == 4'd0))
    else $error("schedule did not start at round 0");

  // a taken non-final round key is followed by the next round
  a_round_advance : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last_round) |=>
      (out_valid && out_round_number == 4'($past(out_round_number) + 4'd1)))
    else $error("round number did not advance by one");

  // no key is taken mid-schedule
  a_no_overlap : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && out_valid) |-> (out_last_round && !out_stall))
    else $error("key taken while schedule in progress");

  // round number stays in range while shown
  a_round_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_round_number <= 4'd10))
    else $error("round number out of range");

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// testbench for the aes-128 key schedule: directed and random keys in, eleven round keys checked per key
`timescale 1ns / 1ps
module tb;

  localparam int unsigned RANDOM_KEYS = 450;
  localparam int unsigned IDLE_LIMIT = 500;
  localparam int unsigned REPORT_MAX = 10;
  localparam int unsigned TAIL_CYCLES = 30;
  localparam int unsigned MAX_WAIT = 17;
  localparam logic [7:0] GF_POLY = 8'h1b;
  localparam logic [7:0] AFFINE_C = 8'h63;
  localparam logic [7:0] FIRST_RCON = 8'h01;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
  } cipher_key_t;

  typedef struct packed {
    logic [aks_pkg::ROUND_W-1:0] rnd;
    logic [63:0]                 hi;
    logic [63:0]                 lo;
    logic                        last;
  } round_key_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [63:0] in_key_high = 64'h0;
  logic [63:0] in_key_low = 64'h0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [3:0] out_round_number;
  logic [63:0] out_round_key_high;
  logic [63:0] out_round_key_low;
  logic out_last_round;

  cipher_key_t key_queue[$];
  round_key_t  round_keys_due[$];
  logic [7:0]  sub_lut [256];

  cipher_key_t next_key;
  round_key_t  want;
  int unsigned key_total = 0;
  int unsigned keys_raised = 0;
  int unsigned keys_taken = 0;
  int unsigned beats_taken = 0;
  int unsigned beats_seen = 0;
  int unsigned due_count = 0;
  int unsigned key_gap = 0;
  int unsigned stall_left = 0;
  int unsigned stall_draw = 0;
  int unsigned idle_cycles = 0;
  int unsigned errors = 0;
  bit in_calm = 1'b0;
  bit out_calm = 1'b0;
  bit moved;
  bit stuck = 1'b0;

  aes128_key_schedule_top u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_key_high       (in_key_high),
    .in_key_low        (in_key_low),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_round_number  (out_round_number),
    .out_round_key_high(out_round_key_high),
    .out_round_key_low (out_round_key_low),
    .out_last_round    (out_last_round)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? GF_POLY : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    logic [7:0] x;
    int i;
    p = 8'h00;
    x = a;
    for (i = 0; i < 8; i++) begin
      if (b[i]) p ^= x;
      x = xtime(x);
    end
    return p;
  endfunction

  // inverse as x^254, then the affine map
  function automatic logic [7:0] sbox_entry(input logic [7:0] b);
    logic [7:0] v;
    int i;
    v = 8'h01;
    for (i = 0; i < 254; i++) v = gf_mul(v, b);
    return v ^ {v[6:0], v[7]} ^ {v[5:0], v[7:6]} ^ {v[4:0], v[7:5]} ^ {v[3:0], v[7:4]}
      ^ AFFINE_C;
  endfunction

  function automatic void expand_key(input logic [63:0] kh, input logic [63:0] kl);
    logic [31:0] w0, w1, w2, w3, t;
    logic [7:0] rc;
    round_key_t rk;
    int r;
    w0 = kh[63:32];
    w1 = kh[31:0];
    w2 = kl[63:32];
    w3 = kl[31:0];
    rc = FIRST_RCON;
    for (r = 0; r <= aks_pkg::LAST_ROUND; r++) begin
      if (r != 0) begin
        t = {sub_lut[w3[23:16]], sub_lut[w3[15:8]], sub_lut[w3[7:0]], sub_lut[w3[31:24]]}
          ^ {rc, 24'h0};
        w0 ^= t;
        w1 ^= w0;
        w2 ^= w1;
        w3 ^= w2;
        rc = xtime(rc);
      end
      rk.rnd = r[aks_pkg::ROUND_W-1:0];
      rk.hi = {w0, w1};
      rk.lo = {w2, w3};
      rk.last = (r == aks_pkg::LAST_ROUND);
      round_keys_due.push_back(rk);
    end
  endfunction

  function automatic logic [63:0] rand_word();
    logic [63:0] w;
    logic [7:0] b;
    case ($urandom_range(0, 5))
      0, 1: w = {$urandom(), $urandom()};
      2: w = 64'h1 << $urandom_range(0, 63);
      3: w = ~(64'h1 << $urandom_range(0, 63));
      4: begin
        b = 8'($urandom_range(0, 255));
        w = {8{b}};
      end
      default: w = {$urandom(), $urandom()} & {$urandom(), $urandom()}
        & {$urandom(), $urandom()};
    endcase
    return w;
  endfunction

  function automatic int unsigned draw_wait(input bit calm);
    return calm ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic void add_key(input logic [63:0] kh, input logic [63:0] kl);
    cipher_key_t k;
    k.hi = kh;
    k.lo = kl;
    key_queue.push_back(k);
    key_total++;
  endfunction

  // key beats
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      key_gap <= 0;
    end else if (in_valid && keys_taken != keys_raised) begin
      // beat held until taken
    end else if (key_gap != 0) begin
      in_valid <= 1'b0;
      key_gap <= key_gap - 1;
    end else if (key_queue.size() != 0) begin
      next_key = key_queue.pop_front();
      in_valid <= 1'b1;
      in_key_high <= next_key.hi;
      in_key_low <= next_key.lo;
      keys_raised <= keys_raised + 1;
      key_gap <= draw_wait(in_calm);
      in_calm <= ($urandom_range(0, 11) == 0) ? !in_calm : in_calm;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // round key stalls
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (beats_seen != beats_taken) begin
      beats_seen <= beats_taken;
      stall_draw = draw_wait(out_calm);
      stall_left <= stall_draw;
      out_stall <= (stall_draw != 0);
      out_calm <= ($urandom_range(0, 40) == 0) ? !out_calm : out_calm;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall <= (stall_left > 1);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      moved = 1'b0;
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        beats_taken <= beats_taken + 1;
        if (round_keys_due.size() == 0) begin
          errors++;
          if (errors <= REPORT_MAX)
            $display("tb: unexpected round key beat: round %0d %h %h last %0b",
                     out_round_number, out_round_key_high, out_round_key_low, out_last_round);
        end else begin
          want = round_keys_due.pop_front();
          if (want.rnd !== out_round_number || want.hi !== out_round_key_high ||
              want.lo !== out_round_key_low || want.last !== out_last_round) begin
            errors++;
            if (errors <= REPORT_MAX)
              $display({"tb: mismatch: expected round %0d %h %h last %0b, ",
                        "got round %0d %h %h last %0b"},
                       want.rnd, want.hi, want.lo, want.last, out_round_number,
                       out_round_key_high, out_round_key_low, out_last_round);
          end
        end
      end
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        keys_taken <= keys_taken + 1;
        expand_key(in_key_high, in_key_low);
      end
      if (moved) idle_cycles <= 0;
      else if (idle_cycles >= IDLE_LIMIT) stuck <= 1'b1;
      else idle_cycles <= idle_cycles + 1;
      due_count <= round_keys_due.size();
    end
  end

  initial begin
    int i;
    for (i = 0; i < 256; i++) sub_lut[i] = sbox_entry(i[7:0]);

    add_key(64'h0, 64'h0);
    add_key({64{1'b1}}, {64{1'b1}});
    add_key(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c);
    add_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
    add_key(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
    add_key(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
    add_key(64'h8000000000000000, 64'h0);
    add_key(64'h0, 64'h1);
    add_key({64{1'b1}}, 64'h0);
    add_key(64'h0, {64{1'b1}});
    add_key(64'h0, 64'h0000000052525252);
    add_key(64'hffffffff00000000, 64'h00000000ffffffff);
    add_key(64'h0123456789abcdef, 64'hfedcba9876543210);
    for (i = 0; i < RANDOM_KEYS; i++) add_key(rand_word(), rand_word());

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (!((keys_taken == key_total && due_count == 0) || stuck)) @(negedge clk);
    if (stuck) begin
      $display("tb: done, errors");
      $finish;
    end else begin
      repeat (TAIL_CYCLES) @(negedge clk);
      if (errors == 0 && round_keys_due.size() == 0) begin
        $display("tb: done, clean");
      end else begin
        $display("tb: done, errors");
      end
      $finish;
    end
  end

endmodule

// ===== filelist.f =====
rtl/aks_pkg.sv
rtl/aks_datapath.sv
rtl/aks_ctrl.sv
rtl/aes128_key_schedule_top.sv
tb/tb.sv
